### rtl/falc_pkg.sv
// shared constants, types and handshake structs for the fully associative lru tag store
// no dependencies; used by the interfaces, falc_ways and the top level
package falc_pkg;

  localparam int WAYS      = 8;
  localparam int ADDR_BITS = 32;
  localparam int IN_BITS   = 32;
  localparam int CNT_BITS  = 32;
  localparam int WAY_BITS  = $clog2(WAYS);
  localparam int RANK_BITS = WAY_BITS;

  typedef logic [ADDR_BITS-1:0] tag_t;
  typedef logic [WAY_BITS-1:0]  way_t;
  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  localparam rank_t RANK_MRU = rank_t'(WAYS - 1);
  localparam cnt_t  CNT_MAX  = '1;

  // one lookup request into the way array
  typedef struct packed {
    logic en;
    tag_t addr;
  } lookup_t;

  // outcome of the lookup in the same cycle
  typedef struct packed {
    logic hit;
    way_t way;
  } outcome_t;

endpackage

### rtl/falc_addr_if.sv
// address channel: valid/ready handshake carrying one lookup address
// depends on falc_pkg
interface falc_addr_if;
  import falc_pkg::*;

  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] lookup_address;

  modport source (output valid, output lookup_address, input ready);
  modport sink   (input valid, input lookup_address, output ready);
endinterface

### rtl/falc_result_if.sv
// result channel: valid/ready handshake carrying hit flag, way and running counts
// depends on falc_pkg
interface falc_result_if;
  import falc_pkg::*;

  logic                valid;
  logic                ready;
  logic                was_hit;
  logic [WAY_BITS-1:0] way_used;
  logic [CNT_BITS-1:0] hits_so_far;
  logic [CNT_BITS-1:0] misses_so_far;

  modport source (output valid, output was_hit, output way_used, output hits_so_far,
                  output misses_so_far, input ready);
  modport sink   (input valid, input was_hit, input way_used, input hits_so_far,
                  input misses_so_far, output ready);
endinterface

### rtl/falc_ways.sv
// tag array, valid bits and lru ranks; parallel compare, victim pick and rank update
// depends on falc_pkg
module falc_ways (
  input  logic               clk,
  input  logic               rst,
  input  falc_pkg::lookup_t  req,
  output falc_pkg::outcome_t res
);
  import falc_pkg::*;

  tag_t  [WAYS-1:0] tag;
  logic  [WAYS-1:0] valid;
  rank_t [WAYS-1:0] rank;
  rank_t [WAYS-1:0] rank_next;

  logic [WAYS-1:0] match;
  logic  hit;
  way_t  hit_way;
  logic  free;
  way_t  free_way;
  way_t  lru_way;
  way_t  way;
  rank_t old_rank;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = valid[i] && (tag[i] == req.addr);
    end
  end

  // lowest matching way wins, lowest empty way is filled first
  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    free     = 1'b0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_way = way_t'(i);
      end
      if (!valid[i]) begin
        free     = 1'b1;
        free_way = way_t'(i);
      end
    end
  end

  // smallest rank, lowest index on a tie
  always_comb begin
    lru_way = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (rank[i] < rank[lru_way]) begin
        lru_way = way_t'(i);
      end
    end
  end

  assign way      = hit ? hit_way : (free ? free_way : lru_way);
  assign old_rank = rank[way];

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (way_t'(i) == way) begin
        rank_next[i] = RANK_MRU;
      end else if (valid[i] && (rank[i] > old_rank)) begin
        rank_next[i] = rank[i] - rank_t'(1);
      end else begin
        rank_next[i] = rank[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rank  <= '0;
    end else if (req.en) begin
      rank <= rank_next;
      if (!hit) begin
        valid[way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.en && !hit) begin
      tag[way] <= req.addr;
    end
  end

  assign res.hit = hit;
  assign res.way = way;

`ifndef SYNTH
  a_mru_after_access: assert property (@(posedge clk) disable iff (rst)
    req.en |=> rank[$past(way)] == RANK_MRU)
    else $error("accessed way did not become most recent");

  a_hit_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    req.en && hit |=> valid == $past(valid))
    else $error("hit changed valid bits");

  a_idle_holds_ranks: assert property (@(posedge clk) disable iff (rst)
    !req.en |=> $stable(rank) && $stable(valid))
    else $error("ranks or valid bits moved without an access");

  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    !rst |=> $countones(valid) >= $countones($past(valid)))
    else $error("a way lost its valid bit");
`endif

endmodule

### rtl/fully_assoc_lru_cache_tags_top.sv
// Fully associative tag store with true lru replacement, eight ways of 32-bit tags.
// One address is accepted per cycle while the result is not stalled, and one result
// transaction comes out for each: the address is held in an input register, then
// compared against all ways, the victim picked and the ranks updated in one registered
// pass, and the result lands in an output register. The rate is set by that single
// pass through the compare and rank update in falc_ways; a new address can be taken in
// while the previous one is processed. A stalled result holds the pipeline, it never
// drops a transaction. Hit and miss counts saturate at all ones. Depends on falc_pkg,
// falc_addr_if, falc_result_if and falc_ways.
module fully_assoc_lru_cache_tags_top (
  input logic          clk,
  input logic          rst,
  falc_addr_if.sink    req,
  falc_result_if.source rsp
);
  import falc_pkg::*;

  logic     in_valid_q;
  tag_t     addr_q;
  logic     out_valid;
  logic     was_hit;
  way_t     way_used;
  cnt_t     hit_total;
  cnt_t     miss_total;
  logic     adv;
  lookup_t  lookup;
  outcome_t outcome;

  assign adv       = in_valid_q && (!out_valid || rsp.ready);
  assign req.ready = !in_valid_q || adv;

  assign lookup.en   = adv;
  assign lookup.addr = addr_q;

  falc_ways u_ways (
    .clk (clk),
    .rst (rst),
    .req (lookup),
    .res (outcome)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else begin
      if (req.ready) begin
        in_valid_q <= req.valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
        if (outcome.hit) begin
          if (hit_total != CNT_MAX) begin
            hit_total <= hit_total + cnt_t'(1);
          end
        end else if (miss_total != CNT_MAX) begin
          miss_total <= miss_total + cnt_t'(1);
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      addr_q <= req.lookup_address[ADDR_BITS-1:0];
    end
    if (adv) begin
      was_hit  <= outcome.hit;
      way_used <= outcome.way;
    end
  end

  // counters only move together with the result register, so they serve as its count fields
  assign rsp.valid         = out_valid;
  assign rsp.was_hit       = was_hit;
  assign rsp.way_used      = way_used;
  assign rsp.hits_so_far   = hit_total;
  assign rsp.misses_so_far = miss_total;

`ifndef SYNTH
  a_one_count_moves: assert property (@(posedge clk) disable iff (rst)
    adv && (hit_total != CNT_MAX) && (miss_total != CNT_MAX) |=>
      ((hit_total != $past(hit_total)) != (miss_total != $past(miss_total))))
    else $error("transaction did not bump exactly one counter");

  a_item_not_dropped: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !adv |=> in_valid_q && $stable(addr_q))
    else $error("held lookup lost while the output was stalled");

  a_result_after_adv: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("processed lookup produced no result");

  a_counts_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (hit_total >= $past(hit_total)) && (miss_total >= $past(miss_total)))
    else $error("running count decreased");
`endif

endmodule

### tb/sv/falc_lru_checker.sv
// watches the address and result channels of the lru tag store, predicts each result
// transaction and compares it with what comes out
// depends on falc_pkg
module falc_lru_checker
  import falc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_ready,
  input  logic [IN_BITS-1:0] lookup_address,
  input  logic               rsp_valid,
  input  logic               rsp_ready,
  input  logic               was_hit,
  input  way_t               way_used,
  input  cnt_t               hits_so_far,
  input  cnt_t               misses_so_far,
  output int unsigned        outstanding,
  output int unsigned        failures
);

  typedef struct packed {
    logic hit;
    way_t way;
    cnt_t hits;
    cnt_t misses;
  } access_outcome_t;

  tag_t            tags [WAYS];
  logic [WAYS-1:0] live;
  rank_t           rank [WAYS];
  cnt_t            hit_total;
  cnt_t            miss_total;
  access_outcome_t pending_outcomes [$];

  // one lookup against the shadow tag store, with fill, eviction and rank update
  function automatic access_outcome_t lru_access(input tag_t addr);
    access_outcome_t res;
    rank_t           old;
    way_t            way;
    logic            hit;
    logic            found;
    hit = 1'b0;
    way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && live[i] && tags[i] == addr) begin
        hit = 1'b1;
        way = way_t'(i);
      end
    end
    if (hit) begin
      if (hit_total != CNT_MAX) hit_total++;
    end else begin
      found = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!found && !live[i]) begin
          found = 1'b1;
          way = way_t'(i);
        end
      end
      // all ways full: lowest numbered way among the smallest ranks
      if (!found) begin
        way = '0;
        for (int i = 1; i < WAYS; i++) begin
          if (rank[i] < rank[way]) way = way_t'(i);
        end
      end
      tags[way] = addr;
      live[way] = 1'b1;
      if (miss_total != CNT_MAX) miss_total++;
    end
    old = rank[way];
    for (int i = 0; i < WAYS; i++) begin
      if (way_t'(i) != way && live[i] && rank[i] > old) rank[i]--;
    end
    rank[way] = RANK_MRU;
    res = '{hit, way, hit_total, miss_total};
    return res;
  endfunction

  always @(posedge clk) begin : track
    access_outcome_t want;
    access_outcome_t got;
    if (rst) begin
      live = '0;
      for (int i = 0; i < WAYS; i++) begin
        rank[i] = '0;
      end
      hit_total = '0;
      miss_total = '0;
      failures = 0;
      pending_outcomes.delete();
    end else begin
      // check before predicting: a transaction never comes out in the edge it went in
      if (rsp_valid && rsp_ready) begin
        got = '{was_hit, way_used, hits_so_far, misses_so_far};
        if (pending_outcomes.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result transaction: hit %0b way %0d hits %0d misses %0d",
                     got.hit, got.way, got.hits, got.misses);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.hit !== want.hit || got.way !== want.way ||
              got.hits !== want.hits || got.misses !== want.misses) begin
            failures++;
            if (failures <= 10)
              $display("result mismatch: expected hit %0b way %0d hits %0d misses %0d, %s",
                       want.hit, want.way, want.hits, want.misses,
                       $sformatf("got hit %0b way %0d hits %0d misses %0d",
                                 got.hit, got.way, got.hits, got.misses));
          end
        end
      end
      if (req_valid && req_ready) pending_outcomes.push_back(lru_access(tag_t'(lookup_address)));
    end
    outstanding = pending_outcomes.size();
  end

endmodule

### tb/sv/tb_top.sv
// top of the lru tag store testbench: clock, reset, address trace with bursty issue,
// stalling result sink, watchdog and verdict
// depends on falc_pkg, falc_addr_if, falc_result_if, falc_lru_checker and the block
module tb_top;
  import falc_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS = 100;

  typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_TOGGLE, SINK_CHOKED} sink_mode_t;

  logic        clk;
  logic        rst;
  int unsigned outstanding;
  int unsigned failures;
  int unsigned idle_cycles;

  falc_addr_if   addr_ch ();
  falc_result_if result_ch ();

  fully_assoc_lru_cache_tags_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (addr_ch),
    .rsp (result_ch)
  );

  falc_lru_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (addr_ch.valid),
    .req_ready      (addr_ch.ready),
    .lookup_address (addr_ch.lookup_address),
    .rsp_valid      (result_ch.valid),
    .rsp_ready      (result_ch.ready),
    .was_hit        (result_ch.was_hit),
    .way_used       (result_ch.way_used),
    .hits_so_far    (result_ch.hits_so_far),
    .misses_so_far  (result_ch.misses_so_far),
    .outstanding    (outstanding),
    .failures       (failures)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result sink: segments of open, random, toggling and mostly stalled ready
  initial begin
    sink_mode_t mode;
    int         seg;
    result_ch.ready = 1'b0;
    forever begin
      mode = sink_mode_t'($urandom_range(3));
      seg = $urandom_range(20, 200);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          SINK_OPEN:   result_ch.ready <= 1'b1;
          SINK_RANDOM: result_ch.ready <= ($urandom_range(3) != 0);
          SINK_TOGGLE: result_ch.ready <= ~result_ch.ready;
          default:     result_ch.ready <= ($urandom_range(7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((addr_ch.valid && addr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [IN_BITS-1:0] lookup_trace [$];
    logic [IN_BITS-1:0] pool [$];
    logic [IN_BITS-1:0] addr;
    int                 pool_size;
    int                 pick;
    int                 idx;
    int                 burst;
    int                 gap;
    rst = 1'b1;
    addr_ch.valid = 1'b0;
    addr_ch.lookup_address = '0;

    // fill from empty, hit on a partly filled store, then evictions in lru order
    lookup_trace = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
                     32'h0000_0001, 32'h5555_5555, 32'hFFFF_FFFE, 32'h1234_5678,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAB,
                     32'h7FFF_FFFF, 32'h0000_0000};

    // working sets of varying size around the way count, with near misses and noise
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pool.delete();
      pool_size = $urandom_range(2, 14);
      for (int j = 0; j < pool_size; j++) begin
        if (j != 0 && $urandom_range(3) == 0)
          pool.push_back(pool[j-1] ^ (32'h1 << $urandom_range(31)));
        else
          pool.push_back($urandom);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(pool_size - 1);
        case ($urandom_range(19))
          0:       addr = $urandom;
          1, 2:    addr = pool[pick] ^ (32'h1 << $urandom_range(31));
          default: addr = pool[pick];
        endcase
        lookup_trace.push_back(addr);
      end
    end

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    idx = 0;
    while (idx < lookup_trace.size()) begin
      burst = ($urandom_range(4) == 0) ? 80 : $urandom_range(1, 24);
      for (int k = 0; k < burst && idx < lookup_trace.size(); k++) begin
        @(negedge clk);
        addr_ch.valid <= 1'b1;
        addr_ch.lookup_address <= lookup_trace[idx];
        do @(posedge clk); while (!addr_ch.ready);
        idx++;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        @(negedge clk);
        addr_ch.valid <= 1'b0;
        addr_ch.lookup_address <= $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    addr_ch.valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/falc_pkg.sv
rtl/falc_addr_if.sv
rtl/falc_result_if.sv
rtl/falc_ways.sv
rtl/fully_assoc_lru_cache_tags_top.sv
tb/sv/falc_lru_checker.sv
tb/sv/tb_top.sv
